[design/unix_path_address_decoder_defines.svh]
// assertion macros shared by the address decoder modules
`ifndef UNIX_PATH_ADDRESS_DECODER_DEFINES_SVH
`define UNIX_PATH_ADDRESS_DECODER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UPAD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upad check failed in same cycle");

// consequent must hold in the cycle after the antecedent
`define UPAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upad check failed in next cycle");

`endif

[design/upad_pkg.sv]
// types, constants and helper functions of the unix path address decoder
`timescale 1ns / 1ps
`default_nettype none

package upad_pkg;

    localparam int PREFIX_LENGTH   = 10;
    localparam int PREFIX_POS_W    = 4;
    localparam int COUNT_WIDTH_DEF = 12;
    localparam int MAX_LEN_W       = 12;
    localparam int FIFO_DEPTH_DEF  = 4;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int REG_INDEX_W     = 1;

    localparam logic [MAX_LEN_W-1:0]   MAX_LEN_RESET       = 12'd107;
    localparam logic [REG_INDEX_W-1:0] REG_MAX_PATH_LENGTH = 1'b0;

    localparam logic REC_BYTE = 1'b0;
    localparam logic REC_END  = 1'b1;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_INVALID     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_PREFIX   = 3'd0,
        PH_BODY     = 3'd1,
        PH_ESC_HIGH = 3'd2,
        PH_ESC_LOW  = 3'd3,
        PH_ERROR    = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       record_kind;
        logic [1:0] status;
        logic       end_of_run;
    } t_out_item;

    // one classified input byte, handed from the front to the back
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] prefix_char(input logic [PREFIX_POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h75; // u
            4'd1:    ch = 8'h6E; // n
            4'd2:    ch = 8'h69; // i
            4'd3:    ch = 8'h78; // x
            4'd4:    ch = 8'h3A; // :
            4'd5:    ch = 8'h70; // p
            4'd6:    ch = 8'h61; // a
            4'd7:    ch = 8'h74; // t
            4'd8:    ch = 8'h68; // h
            4'd9:    ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c >= CH_0 && c <= CH_9) begin
            d = {1'b0, 4'(c - CH_0)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = {1'b0, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = {1'b0, 4'(c - CH_UA + 8'd10)};
        end else begin
            d = 5'h10;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[design/upad_front.sv]
// front end: prefix match, percent decode and path checks; one byte per cycle unless i_full
`timescale 1ns / 1ps
`default_nettype none
`include "unix_path_address_decoder_defines.svh"

module upad_front #(
    parameter int COUNT_WIDTH = upad_pkg::COUNT_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  upad_pkg::t_in_item                i_in,
    input  wire  [upad_pkg::MAX_LEN_W-1:0]    i_max_path_length,
    output logic                              o_push,
    output upad_pkg::t_entry                  o_entry,
    input  wire                               i_full
);
    import upad_pkg::*;

    localparam int CmpW = (COUNT_WIDTH > MAX_LEN_W) ? COUNT_WIDTH : MAX_LEN_W;
    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
    localparam logic [PREFIX_POS_W-1:0] PrefixLast = PREFIX_POS_W'(PREFIX_LENGTH - 1);

    t_phase                  r_phase, n_phase;
    logic [PREFIX_POS_W-1:0] r_prefix_pos, n_prefix_pos;
    logic [3:0]              r_high_nibble, n_high_nibble;
    logic [COUNT_WIDTH-1:0]  r_path_count, n_path_count;
    logic                    r_first_slash, n_first_slash;
    t_status                 r_err_status, n_err_status;

    logic       accept;
    logic [7:0] c;
    logic [4:0] digit;
    logic       digit_ok;
    logic [7:0] esc_byte;
    logic       prefix_match;
    logic       room;
    logic       emit;
    logic [7:0] ob;
    t_status    end_status;

    assign o_in_ready   = !i_full;
    assign accept       = i_in_valid && !i_full;
    assign c            = i_in.in_byte;
    assign digit        = hex_digit(c);
    assign digit_ok     = !digit[4];
    assign esc_byte     = {r_high_nibble, digit[3:0]};
    assign prefix_match = (r_prefix_pos <= PrefixLast) && (c == prefix_char(r_prefix_pos));
    // path byte fits under the configured limit and the counter range
    assign room = (CmpW'(r_path_count) < CmpW'(i_max_path_length))
               && (r_path_count != CountMax);

    // next parse phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_PREFIX: begin
                if (!prefix_match) begin
                    n_phase = PH_ERROR;
                end else if (r_prefix_pos == PrefixLast) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (c == CH_COMMA || c == CH_SEMI) begin
                    n_phase = PH_ERROR;
                end else if (c == CH_PERCENT) begin
                    n_phase = PH_ESC_HIGH;
                end else if (!room) begin
                    n_phase = PH_ERROR;
                end
            end
            PH_ESC_HIGH: begin
                n_phase = digit_ok ? PH_ESC_LOW : PH_ERROR;
            end
            PH_ESC_LOW: begin
                if (!digit_ok || esc_byte == 8'h00 || !room) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_ERROR: n_phase = PH_ERROR;
            default:  n_phase = PH_ERROR;
        endcase
    end

    // emitted byte and datapath updates
    always_comb begin
        emit          = 1'b0;
        ob            = c;
        n_prefix_pos  = r_prefix_pos;
        n_high_nibble = r_high_nibble;
        n_err_status  = r_err_status;
        unique case (r_phase)
            PH_PREFIX: begin
                if (prefix_match) begin
                    n_prefix_pos = r_prefix_pos + 1'b1;
                end else begin
                    n_err_status = ST_UNSUPPORTED;
                end
            end
            PH_BODY: begin
                if (c == CH_COMMA || c == CH_SEMI) begin
                    n_err_status = ST_INVALID;
                end else if (c != CH_PERCENT) begin
                    if (room) begin
                        emit = 1'b1;
                    end else begin
                        n_err_status = ST_INVALID;
                    end
                end
            end
            PH_ESC_HIGH: begin
                if (digit_ok) begin
                    n_high_nibble = digit[3:0];
                end else begin
                    n_err_status = ST_INVALID;
                end
            end
            PH_ESC_LOW: begin
                ob = esc_byte;
                if (!digit_ok || esc_byte == 8'h00 || !room) begin
                    n_err_status = ST_INVALID;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ERROR: begin
                n_err_status = r_err_status;
            end
            default: begin
                n_err_status = r_err_status;
            end
        endcase
    end

    always_comb begin
        n_path_count  = r_path_count;
        n_first_slash = r_first_slash;
        if (emit) begin
            n_path_count = r_path_count + 1'b1;
            if (r_path_count == '0) begin
                n_first_slash = (ob == CH_SLASH);
            end
        end
    end

    // status of the end record, taken from the state after this byte
    always_comb begin
        if (n_phase == PH_ERROR) begin
            end_status = n_err_status;
        end else if (n_phase == PH_PREFIX) begin
            end_status = ST_UNSUPPORTED;
        end else if (n_phase != PH_BODY) begin
            end_status = ST_INVALID;
        end else if (n_path_count == '0 || !n_first_slash) begin
            end_status = ST_INVALID;
        end else begin
            end_status = ST_OK;
        end
    end

    assign o_push         = accept && (emit || i_in.in_last);
    assign o_entry.emit   = emit;
    assign o_entry.data   = ob;
    assign o_entry.last   = i_in.in_last;
    assign o_entry.status = end_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PREFIX;
            r_prefix_pos  <= '0;
            r_high_nibble <= '0;
            r_path_count  <= '0;
            r_first_slash <= 1'b0;
            r_err_status  <= ST_OK;
        end else if (accept) begin
            if (i_in.in_last) begin
                // address done, start over for the next one
                r_phase       <= PH_PREFIX;
                r_prefix_pos  <= '0;
                r_high_nibble <= '0;
                r_path_count  <= '0;
                r_first_slash <= 1'b0;
                r_err_status  <= ST_OK;
            end else begin
                r_phase       <= n_phase;
                r_prefix_pos  <= n_prefix_pos;
                r_high_nibble <= n_high_nibble;
                r_path_count  <= n_path_count;
                r_first_slash <= n_first_slash;
                r_err_status  <= n_err_status;
            end
        end
    end

    `UPAD_ASSERT_SAME(a_error_has_code, i_clk, i_rst_n, r_phase == PH_ERROR, r_err_status != ST_OK)
    `UPAD_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, accept && i_in.in_last, r_phase == PH_PREFIX && r_path_count == '0 && r_prefix_pos == '0)

endmodule

`default_nettype wire

[design/upad_fifo.sv]
// short request queue between the front end and the result stage
`timescale 1ns / 1ps
`default_nettype none
`include "unix_path_address_decoder_defines.svh"

module upad_fifo #(
    parameter int FIFO_DEPTH = upad_pkg::FIFO_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  upad_pkg::t_entry      i_entry,
    input  wire                   i_pop,
    output upad_pkg::t_entry      o_entry,
    output upad_pkg::t_q_status   o_status
);
    import upad_pkg::*;

    localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CntW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

    t_entry          r_mem [FIFO_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CntFull);
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `UPAD_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, !o_status.full)
    `UPAD_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, !o_status.empty)

endmodule

`default_nettype wire

[design/upad_back.sv]
// result stage: turns queued requests into result records behind an output register
`timescale 1ns / 1ps
`default_nettype none
`include "unix_path_address_decoder_defines.svh"

module upad_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  upad_pkg::t_entry      i_entry,
    input  upad_pkg::t_q_status   i_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output upad_pkg::t_out_item   o_out
);
    import upad_pkg::*;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    // end record still owed after a path byte from the same request
    logic      r_pend, n_pend;
    t_status   r_pend_status, n_pend_status;
    logic      load;

    assign load        = !r_out_valid || i_out_ready;
    assign o_pop       = load && !r_pend && !i_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_pend        = r_pend;
        n_pend_status = r_pend_status;
        if (load) begin
            n_out_valid = 1'b0;
            if (r_pend) begin
                n_out_valid       = 1'b1;
                n_out.out_byte    = 8'h00;
                n_out.record_kind = REC_END;
                n_out.status      = r_pend_status;
                n_out.end_of_run  = 1'b1;
                n_pend            = 1'b0;
            end else if (o_pop) begin
                n_out_valid = 1'b1;
                if (i_entry.emit) begin
                    n_out.out_byte    = i_entry.data;
                    n_out.record_kind = REC_BYTE;
                    n_out.status      = ST_OK;
                    n_out.end_of_run  = !i_entry.last;
                    n_pend            = i_entry.last;
                    n_pend_status     = i_entry.status;
                end else begin
                    n_out.out_byte    = 8'h00;
                    n_out.record_kind = REC_END;
                    n_out.status      = i_entry.status;
                    n_out.end_of_run  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out         <= n_out;
        r_pend_status <= n_pend_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    `UPAD_ASSERT_SAME(a_end_closes_run, i_clk, i_rst_n, r_out_valid && r_out.record_kind == REC_END, r_out.end_of_run)
    `UPAD_ASSERT_SAME(a_split_has_pending, i_clk, i_rst_n, r_out_valid && r_out.record_kind == REC_BYTE && !r_out.end_of_run, r_pend)

endmodule

`default_nettype wire

[design/unix_path_address_decoder.sv]
// Decoder for "unix:path=" socket addresses fed one character per request. It takes one
// input byte per clock cycle while the queue is not full; the front end classifies each
// byte combinationally and queues at most one request, and the result stage drains one
// record per cycle while the consumer is ready, from a small queue through a registered
// output. A byte that ends the address and also yields a path byte produces two records;
// the queue absorbs this, so input stalls only when the consumer is slower than one record
// per cycle. Path bytes stream out as they are decoded; the end record carries the status
// (ok, unsupported prefix, invalid) and the consumer drops the streamed bytes unless it is
// ok. Register max_path_length sits at byte address 0 of the APB port and resets to 107;
// the user must write it only while the block is idle, as the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module unix_path_address_decoder #(
    parameter int COUNT_WIDTH = upad_pkg::COUNT_WIDTH_DEF,
    parameter int FIFO_DEPTH  = upad_pkg::FIFO_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  upad_pkg::t_in_item                 i_in,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output upad_pkg::t_out_item                o_out,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [upad_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [upad_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [upad_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import upad_pkg::*;

    logic [MAX_LEN_W-1:0]   r_max_path_length;
    logic [REG_INDEX_W-1:0] reg_index;
    logic                   push;
    logic                   pop;
    t_entry                 push_entry;
    t_entry                 head_entry;
    t_q_status              q_status;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_path_length <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_index == REG_MAX_PATH_LENGTH) begin
            r_max_path_length <= pwdata[MAX_LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_MAX_PATH_LENGTH) begin
            prdata = APB_DATA_W'(r_max_path_length);
        end
    end

    upad_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in              (i_in),
        .i_max_path_length (r_max_path_length),
        .o_push            (push),
        .o_entry           (push_entry),
        .i_full            (q_status.full)
    );

    upad_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    upad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head_entry),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[test/unix_path_address_decoder_checker.sv]
// checker for the address decoder: mirrors the decode, holds expected records, compares
`timescale 1ns / 1ps

module unix_path_address_decoder_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  upad_pkg::t_in_item               i_in,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  upad_pkg::t_out_item              i_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [upad_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [upad_pkg::APB_DATA_W-1:0]  pwdata,
    input  wire                              pready,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_records,
    output int                               o_ends_ok,
    output int                               o_ends_unsup,
    output int                               o_ends_invalid
);

    import upad_pkg::*;

    localparam int                      CNT_W        = COUNT_WIDTH_DEF;
    localparam logic [CNT_W-1:0]        COUNT_CEIL   = '1;
    localparam logic [8*PREFIX_LENGTH-1:0] PREFIX_TEXT = "unix:path=";
    localparam logic [APB_ADDR_W-1:0]   MAX_LEN_ADDR = APB_ADDR_W'(4 * REG_MAX_PATH_LENGTH);
    localparam int                      SHOW_LIMIT   = 100;

    // decode state of the address in flight
    t_phase                  phase;
    logic [PREFIX_POS_W-1:0] pfx_pos;
    logic [3:0]              hi_nib;
    logic [CNT_W-1:0]        path_cnt;
    logic                    first_slash;
    t_status                 err_st;
    logic [MAX_LEN_W-1:0]    max_len;

    t_out_item expected_records[$];

    int fail_n     = 0;
    int pending_n  = 0;
    int records_n  = 0;
    int ok_n       = 0;
    int unsup_n    = 0;
    int invalid_n  = 0;

    assign o_fail_count   = fail_n;
    assign o_pending      = pending_n;
    assign o_records      = records_n;
    assign o_ends_ok      = ok_n;
    assign o_ends_unsup   = unsup_n;
    assign o_ends_invalid = invalid_n;

    function automatic logic [7:0] prefix_at(input logic [PREFIX_POS_W-1:0] pos);
        return PREFIX_TEXT[8*(PREFIX_LENGTH-1-int'(pos)) +: 8];
    endfunction

    // bit 4 flags a character that is not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c >= CH_0 && c <= CH_9) begin
            return {1'b0, c[3:0]};
        end
        if (lc >= CH_LA && lc <= CH_LF) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    task automatic clear_parse();
        phase       = PH_PREFIX;
        pfx_pos     = '0;
        hi_nib      = '0;
        path_cnt    = '0;
        first_slash = 1'b0;
        err_st      = ST_OK;
    endtask

    task automatic latch_error(input t_status code);
        phase  = PH_ERROR;
        err_st = code;
    endtask

    // a decoded byte is streamed only while the path is within the length limit
    task automatic count_byte(input logic [7:0] b, output logic fits);
        if (path_cnt >= CNT_W'(max_len) || path_cnt == COUNT_CEIL) begin
            latch_error(ST_INVALID);
            fits = 1'b0;
        end else begin
            if (path_cnt == '0) begin
                first_slash = (b == CH_SLASH);
            end
            path_cnt = path_cnt + 1'b1;
            fits     = 1'b1;
        end
    endtask

    task automatic take_byte(input logic [7:0] c, input logic last);
        logic       emit;
        logic       fits;
        logic [4:0] d;
        logic [7:0] ob;
        t_status    st;
        emit = 1'b0;
        fits = 1'b0;
        ob   = c;
        d    = nibble_of(c);
        case (phase)
            PH_PREFIX: begin
                if (c == prefix_at(pfx_pos)) begin
                    pfx_pos = pfx_pos + 1'b1;
                    if (pfx_pos == PREFIX_LENGTH) begin
                        phase = PH_BODY;
                    end
                end else begin
                    latch_error(ST_UNSUPPORTED);
                end
            end
            PH_BODY: begin
                if (c == CH_COMMA || c == CH_SEMI) begin
                    latch_error(ST_INVALID);
                end else if (c == CH_PERCENT) begin
                    phase = PH_ESC_HIGH;
                end else begin
                    count_byte(c, fits);
                    emit = fits;
                end
            end
            PH_ESC_HIGH: begin
                if (d[4]) begin
                    latch_error(ST_INVALID);
                end else begin
                    hi_nib = d[3:0];
                    phase  = PH_ESC_LOW;
                end
            end
            PH_ESC_LOW: begin
                ob = {hi_nib, d[3:0]};
                if (d[4] || ob == 8'h00) begin
                    latch_error(ST_INVALID);
                end else begin
                    phase = PH_BODY;
                    count_byte(ob, fits);
                    emit = fits;
                end
            end
            default: begin
                // error phase swallows the rest of the address
                phase = PH_ERROR;
            end
        endcase

        if (emit) begin
            expected_records.push_back('{out_byte: ob, record_kind: REC_BYTE,
                                         status: ST_OK, end_of_run: !last});
        end
        if (last) begin
            if (phase == PH_ERROR) begin
                st = err_st;
            end else if (phase == PH_PREFIX) begin
                st = ST_UNSUPPORTED;
            end else if (phase != PH_BODY || path_cnt == '0 || !first_slash) begin
                st = ST_INVALID;
            end else begin
                st = ST_OK;
            end
            case (st)
                ST_OK:          ok_n++;
                ST_UNSUPPORTED: unsup_n++;
                default:        invalid_n++;
            endcase
            expected_records.push_back('{out_byte: 8'h00, record_kind: REC_END,
                                         status: st, end_of_run: 1'b1});
            clear_parse();
        end
    endtask

    task automatic check_record(input t_out_item got);
        t_out_item want;
        if (expected_records.size() == 0) begin
            if (fail_n < SHOW_LIMIT) begin
                $display("%0t: unexpected record byte %02h kind %0d status %0d eor %0d",
                         $time, got.out_byte, got.record_kind, got.status, got.end_of_run);
            end
            fail_n++;
        end else begin
            want = expected_records.pop_front();
            records_n++;
            if (got !== want) begin
                if (fail_n < SHOW_LIMIT) begin
                    $display("%0t: record mismatch, expected byte %02h kind %0d status %0d eor %0d",
                             $time, want.out_byte, want.record_kind, want.status,
                             want.end_of_run);
                    $display("%0t:                  actual byte %02h kind %0d status %0d eor %0d",
                             $time, got.out_byte, got.record_kind, got.status, got.end_of_run);
                end
                fail_n++;
            end
        end
        if (fail_n == SHOW_LIMIT) begin
            $display("%0t: further mismatch reports suppressed", $time);
            fail_n++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len = MAX_LEN_RESET;
            clear_parse();
            expected_records.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR) begin
                max_len = pwdata[MAX_LEN_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                take_byte(i_in.in_byte, i_in.in_last);
            end
            if (i_out_valid && i_out_ready) begin
                check_record(i_out);
            end
        end
        pending_n = expected_records.size();
    end

endmodule

[test/unix_path_address_decoder_tb.sv]
// testbench top for the address decoder: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 1ps

module unix_path_address_decoder_tb;

    import upad_pkg::*;

    localparam int                    CYCLE_LIMIT  = 1000000;
    localparam int                    SETTLE       = 8;
    localparam string                 PREFIX_STR   = "unix:path=";
    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = APB_ADDR_W'(4 * REG_MAX_PATH_LENGTH);

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in        = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_out_item             o_out;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int records;
    int ends_ok;
    int ends_unsup;
    int ends_invalid;

    logic [7:0] addr_q[$];
    bit         quiet      = 1'b0;
    int         stall_left = 0;
    int         cycle_n    = 0;
    int         items_n    = 0;
    int         addr_n     = 0;
    int         config_n   = 0;
    int         max_len_now = MAX_LEN_RESET;

    unix_path_address_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    unix_path_address_decoder_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in           (i_in),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out          (o_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_records      (records),
        .o_ends_ok      (ends_ok),
        .o_ends_unsup   (ends_unsup),
        .o_ends_invalid (ends_invalid)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d records outstanding", cycle_n, pending);
            $display("unix_path_address_decoder: mismatch");
            $finish;
        end
    end

    // consumer stalls in random bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) begin
            return CH_0 + 8'(v);
        end
        return (upper ? CH_UA : CH_LA) + 8'(v) - 8'd10;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] b);
        return (b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UF) ||
               (b >= CH_LA && b <= CH_LF);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // a byte that passes through the body unescaped
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = any_byte();
        end while (b == CH_COMMA || b == CH_SEMI || b == CH_PERCENT);
        return b;
    endfunction

    // sender: random gap, then hold the request until it is taken
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{in_byte: b, in_last: last};
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_n++;
        @(negedge i_clk);
    endtask

    task automatic send_address();
        for (int k = 0; k < addr_q.size(); k++) begin
            send_item(addr_q[k], k == addr_q.size() - 1);
        end
        addr_n++;
        addr_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            addr_q.push_back(s[k]);
        end
    endtask

    task automatic push_prefix(input int count);
        for (int k = 0; k < count; k++) begin
            addr_q.push_back(PREFIX_STR[k]);
        end
    endtask

    task automatic push_tail();
        repeat ($urandom_range(0, 5)) addr_q.push_back(any_byte());
    endtask

    // reserved characters must be escaped, the rest only now and then
    task automatic push_path_byte(input logic [7:0] b);
        if (b == CH_COMMA || b == CH_SEMI || b == CH_PERCENT || $urandom_range(0, 4) == 0) begin
            addr_q.push_back(CH_PERCENT);
            addr_q.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
            addr_q.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
        end else begin
            addr_q.push_back(b);
        end
    endtask

    task automatic push_path(input int n, input bit slash_first);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            if (k > 0) begin
                b = any_byte();
            end else if (slash_first) begin
                b = CH_SLASH;
            end else begin
                do begin
                    b = any_byte();
                end while (b == CH_SLASH);
            end
            push_path_byte(b);
        end
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_address();
    endtask

    // mostly well-formed addresses with random content, the rest broken or noise
    task automatic make_address();
        int         kind;
        int         n;
        int         p;
        logic [7:0] b;
        kind = $urandom_range(0, 19);
        n    = $urandom_range(1, 10);
        if (kind == 10 && max_len_now <= 200) begin
            n = max_len_now;
        end
        if (kind == 11 && max_len_now <= 200) begin
            n = max_len_now + $urandom_range(1, 3);
        end
        if (kind <= 11) begin
            push_prefix(PREFIX_LENGTH);
            push_path(n, 1'b1);
        end else begin
            case (kind)
                12: begin
                    p = $urandom_range(0, PREFIX_LENGTH - 1);
                    push_prefix(p);
                    do begin
                        b = any_byte();
                    end while (b == PREFIX_STR[p]);
                    addr_q.push_back(b);
                    push_tail();
                end
                13: begin
                    push_prefix($urandom_range(1, PREFIX_LENGTH - 1));
                end
                14: begin
                    push_prefix(PREFIX_LENGTH);
                    push_path($urandom_range(0, 4), 1'b1);
                    addr_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
                    push_tail();
                end
                15: begin
                    push_prefix(PREFIX_LENGTH);
                    push_path($urandom_range(0, 3), 1'b1);
                    addr_q.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1)) begin
                        addr_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                                  1'($urandom_range(0, 1))));
                    end
                    do begin
                        b = any_byte();
                    end while (is_hex_char(b));
                    addr_q.push_back(b);
                    push_tail();
                end
                16: begin
                    // escape cut off by the end of the address
                    push_prefix(PREFIX_LENGTH);
                    push_path($urandom_range(0, 3), 1'b1);
                    addr_q.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1)) begin
                        addr_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                                  1'($urandom_range(0, 1))));
                    end
                end
                17: begin
                    push_prefix(PREFIX_LENGTH);
                    push_path($urandom_range(0, 3), 1'b1);
                    addr_q.push_back(CH_PERCENT);
                    addr_q.push_back(CH_0);
                    addr_q.push_back(CH_0);
                    push_tail();
                end
                18: begin
                    push_prefix(PREFIX_LENGTH);
                    if ($urandom_range(0, 1)) begin
                        push_path($urandom_range(1, 5), 1'b0);
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 8)) addr_q.push_back(any_byte());
                end
            endcase
        end
    endtask

    task automatic run_phase(input int budget);
        int start_n;
        start_n = items_n;
        while (items_n - start_n < budget) begin
            make_address();
            send_address();
        end
    endtask

    // let every expected record drain, then wait out work that emits nothing
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
        wait_drained();
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= APB_DATA_W'(v);
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_len_now = v;
        config_n++;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed addresses at the reset length limit
        send_text("unix:path=/a");
        send_text("unix:path=/%41%6a%Ff%7E");
        send_text("unix:paTh=/x");
        send_text("unix:pa");
        send_text("u");
        send_text("x");
        send_text("unix:path=");
        send_text("unix:path=abc");
        send_text("unix:path=%2Fok");
        send_text("unix:path=/a,b");
        send_text("unix:path=/a;b");
        send_text("unix:path=/%g1");
        send_text("unix:path=/%1z");
        send_text("unix:path=/%4");
        send_text("unix:path=/%");
        send_text("unix:path=/%00x");
        push_text("unix:path=/");
        addr_q.push_back(8'hFF);
        addr_q.push_back(8'h01);
        send_address();

        write_max_len(12'd1);
        send_text("unix:path=/");
        send_text("unix:path=/a");
        run_phase(80);

        // long plain path under the widest limit
        write_max_len(12'd4095);
        push_text("unix:path=/");
        repeat (40) addr_q.push_back(plain_byte());
        send_address();
        run_phase(60);

        write_max_len(12'd3);
        run_phase(50);
        wait_drained();
        run_phase(50);

        write_max_len(MAX_LEN_W'($urandom_range(2, 40)));
        run_phase(80);

        // closing stretch without any idling
        write_max_len(MAX_LEN_RESET);
        quiet = 1'b1;
        run_phase(100);

        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        $display("sent %0d request bytes in %0d addresses over %0d length limit settings",
                 items_n, addr_n, config_n + 1);
        $display("compared %0d records; end status ok %0d, unsupported %0d, invalid %0d",
                 records, ends_ok, ends_unsup, ends_invalid);
        if (fail_count == 0 && pending == 0) begin
            $display("unix_path_address_decoder: match");
        end else begin
            $display("unix_path_address_decoder: mismatch");
        end
        $finish;
    end

endmodule
